// ===== src/ecg_rpd_pkg.sv =====
// ============================================================================
// ecg_rpd_pkg - shared types and constants for the r-peak detector
// widths, reset values, register codes, controller states, command and
// status bundles and the level tracking function
// ============================================================================
package ecg_rpd_pkg;

    // fixed point format of the signal and noise levels
    localparam int LEVEL_FRACTION_BITS = 8;
    localparam int LVL_W   = 16 + LEVEL_FRACTION_BITS;
    localparam int MAG_W   = 17;
    localparam int TRK_W   = LVL_W + 3;
    localparam int THR_W   = MAG_W + LEVEL_FRACTION_BITS + 3;

    // field widths
    localparam int SMP_W   = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int RATE_W  = 16;
    localparam int CNT_W   = 16;
    localparam int SUM_W   = 32;

    // divider
    localparam int DIV_W     = 32;
    localparam int DIV_HALF  = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int RATE_NUM  = 60000;

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // register reset values
    localparam logic [CFG_W-1:0]  RST_MIN_THR  = CFG_W'(900);
    localparam logic [CFG_W-1:0]  RST_REFR     = CFG_W'(400);
    localparam logic [CFG_W-1:0]  RST_WIN_MS   = CFG_W'(5000);
    localparam logic [CFG_W-1:0]  RST_RR_LOW   = CFG_W'(250);
    localparam logic [CFG_W-1:0]  RST_RR_HIGH  = CFG_W'(2000);
    localparam logic [TIME_W-1:0] RST_INIT_WS  = '0;

    // register index codes (byte address / 4)
    typedef enum logic [2:0] {
        REG_MIN_THR  = 3'd0,
        REG_REFR     = 3'd1,
        REG_WIN_MS   = 3'd2,
        REG_RR_LOW   = 3'd3,
        REG_RR_HIGH  = 3'd4,
        REG_INIT_WS  = 3'd5
    } t_reg_idx;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_CALC = 3'd1,
        S_CHK  = 3'd2,
        S_INST = 3'd3,
        S_AVG  = 3'd4,
        S_OUT  = 3'd5
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0]  min_thr;
        logic [CFG_W-1:0]  refr;
        logic [CFG_W-1:0]  win_ms;
        logic [CFG_W-1:0]  rr_low;
        logic [CFG_W-1:0]  rr_high;
        logic [TIME_W-1:0] init_ws;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic calc;
        logic div_start;
        logic div_avg;
        logic cap_inst;
        logic cap_avg;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_inst;
        logic need_avg;
        logic div_done;
    } t_sts;

    // level moves 1/8 of the way toward the magnitude
    function automatic logic [LVL_W-1:0] track_level(input logic [LVL_W-1:0] level,
                                                     input logic [MAG_W-1:0] mag);
        logic [TRK_W-1:0] scaled;
        logic [TRK_W-1:0] acc;
        scaled = TRK_W'(mag) << LEVEL_FRACTION_BITS;
        acc    = scaled + (TRK_W'(level) << 3) - TRK_W'(level);
        return acc[TRK_W-1:3];
    endfunction

endpackage

// ===== src/ecg_rpd_ifs.sv =====
// ============================================================================
// ecg_rpd_ifs - sample and result channels
// valid/ready channels carrying one sample beat and one result beat
// ============================================================================
interface ecg_rpd_smp_if;
    logic                                valid;
    logic                                ready;
    logic signed [ecg_rpd_pkg::SMP_W-1:0] sample_value;
    logic [ecg_rpd_pkg::TIME_W-1:0]      sample_time;

    modport source (output valid, sample_value, sample_time, input ready);
    modport sink   (input valid, sample_value, sample_time, output ready);
endinterface

interface ecg_rpd_res_if;
    logic                             valid;
    logic                             ready;
    logic                             peak_found;
    logic [ecg_rpd_pkg::TIME_W-1:0]   peak_time;
    logic [ecg_rpd_pkg::RATE_W-1:0]   rr_interval;
    logic [ecg_rpd_pkg::RATE_W-1:0]   instant_rate;
    logic [ecg_rpd_pkg::RATE_W-1:0]   average_rate;

    modport source (output valid, peak_found, peak_time, rr_interval, instant_rate,
                    average_rate, input ready);
    modport sink   (input valid, peak_found, peak_time, rr_interval, instant_rate,
                    average_rate, output ready);
endinterface

// ===== src/ecg_rpd_cfg.sv =====
// ============================================================================
// ecg_rpd_cfg - configuration register file
// apb-style write and read of the six detector settings
// ============================================================================
module ecg_rpd_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ecg_rpd_pkg::PADDR_W-1:0]  paddr,
    input  logic [ecg_rpd_pkg::PDATA_W-1:0]  pwdata,
    output logic [ecg_rpd_pkg::PDATA_W-1:0]  prdata,
    output logic                             pready,
    output ecg_rpd_pkg::t_cfg                o_cfg,
    output logic                             o_ws_load,
    output logic [ecg_rpd_pkg::TIME_W-1:0]   o_ws_value
);

    ecg_rpd_pkg::t_cfg     r_cfg;
    ecg_rpd_pkg::t_reg_idx w_idx;
    logic                  w_wr;

    assign w_idx      = ecg_rpd_pkg::t_reg_idx'(paddr[ecg_rpd_pkg::PADDR_W-1:2]);
    assign w_wr       = psel & penable & pwrite;
    assign pready     = 1'b1;
    assign o_cfg      = r_cfg;
    assign o_ws_load  = w_wr && (w_idx == ecg_rpd_pkg::REG_INIT_WS);
    assign o_ws_value = pwdata[ecg_rpd_pkg::TIME_W-1:0];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_thr <= ecg_rpd_pkg::RST_MIN_THR;
            r_cfg.refr    <= ecg_rpd_pkg::RST_REFR;
            r_cfg.win_ms  <= ecg_rpd_pkg::RST_WIN_MS;
            r_cfg.rr_low  <= ecg_rpd_pkg::RST_RR_LOW;
            r_cfg.rr_high <= ecg_rpd_pkg::RST_RR_HIGH;
            r_cfg.init_ws <= ecg_rpd_pkg::RST_INIT_WS;
        end else if (w_wr) begin
            unique case (w_idx)
                ecg_rpd_pkg::REG_MIN_THR: r_cfg.min_thr <= pwdata[ecg_rpd_pkg::CFG_W-1:0];
                ecg_rpd_pkg::REG_REFR:    r_cfg.refr    <= pwdata[ecg_rpd_pkg::CFG_W-1:0];
                ecg_rpd_pkg::REG_WIN_MS:  r_cfg.win_ms  <= pwdata[ecg_rpd_pkg::CFG_W-1:0];
                ecg_rpd_pkg::REG_RR_LOW:  r_cfg.rr_low  <= pwdata[ecg_rpd_pkg::CFG_W-1:0];
                ecg_rpd_pkg::REG_RR_HIGH: r_cfg.rr_high <= pwdata[ecg_rpd_pkg::CFG_W-1:0];
                ecg_rpd_pkg::REG_INIT_WS: r_cfg.init_ws <= pwdata[ecg_rpd_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            ecg_rpd_pkg::REG_MIN_THR: prdata = ecg_rpd_pkg::PDATA_W'(r_cfg.min_thr);
            ecg_rpd_pkg::REG_REFR:    prdata = ecg_rpd_pkg::PDATA_W'(r_cfg.refr);
            ecg_rpd_pkg::REG_WIN_MS:  prdata = ecg_rpd_pkg::PDATA_W'(r_cfg.win_ms);
            ecg_rpd_pkg::REG_RR_LOW:  prdata = ecg_rpd_pkg::PDATA_W'(r_cfg.rr_low);
            ecg_rpd_pkg::REG_RR_HIGH: prdata = ecg_rpd_pkg::PDATA_W'(r_cfg.rr_high);
            ecg_rpd_pkg::REG_INIT_WS: prdata = ecg_rpd_pkg::PDATA_W'(r_cfg.init_ws);
            default:                  prdata = '0;
        endcase
    end

endmodule

// ===== src/ecg_rpd_div.sv =====
// ============================================================================
// ecg_rpd_div - iterative restoring divider
// one quotient bit per cycle; short mode runs half the steps on a
// half-width dividend
// ============================================================================
module ecg_rpd_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_short,
    input  logic [ecg_rpd_pkg::DIV_W-1:0]      i_dividend,
    input  logic [ecg_rpd_pkg::DIV_W-1:0]      i_divisor,
    output logic                               o_done,
    output logic [ecg_rpd_pkg::DIV_W-1:0]      o_quotient
);

    localparam int W  = ecg_rpd_pkg::DIV_W;
    localparam int H  = ecg_rpd_pkg::DIV_HALF;
    localparam int CW = ecg_rpd_pkg::DIV_CNT_W;

    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_div;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [W:0]    w_sh;
    logic [W:0]    w_diff;
    logic          w_ge;
    logic          w_load;

    // one trial subtraction
    assign w_sh   = {r_rem, r_quo[W-1]};
    assign w_ge   = w_sh >= {1'b0, r_div};
    assign w_diff = w_sh - {1'b0, r_div};
    assign w_load = i_start && (r_cnt == '0);

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (w_load) begin
                r_cnt <= i_short ? CW'(H) : CW'(W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rem <= '0;
            r_quo <= i_short ? {i_dividend[H-1:0], H'(0)} : i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[W-1:0] : w_sh[W-1:0];
            r_quo <= {r_quo[W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/ecg_rpd_dp.sv =====
// ============================================================================
// ecg_rpd_dp - detector datapath
// candidate test, level tracking, rr statistics, rate window, divider
// and the result register
// ============================================================================
module ecg_rpd_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ecg_rpd_pkg::t_cfg                       i_cfg,
    input  logic                                    i_ws_load,
    input  logic [ecg_rpd_pkg::TIME_W-1:0]          i_ws_value,
    input  logic signed [ecg_rpd_pkg::SMP_W-1:0]    i_sample_value,
    input  logic [ecg_rpd_pkg::TIME_W-1:0]          i_sample_time,
    input  ecg_rpd_pkg::t_cmd                       i_cmd,
    output ecg_rpd_pkg::t_sts                       o_sts,
    output logic                                    o_peak_found,
    output logic [ecg_rpd_pkg::TIME_W-1:0]          o_peak_time,
    output logic [ecg_rpd_pkg::RATE_W-1:0]          o_rr_interval,
    output logic [ecg_rpd_pkg::RATE_W-1:0]          o_instant_rate,
    output logic [ecg_rpd_pkg::RATE_W-1:0]          o_average_rate
);

    localparam int F   = ecg_rpd_pkg::LEVEL_FRACTION_BITS;
    localparam int LW  = ecg_rpd_pkg::LVL_W;
    localparam int MW  = ecg_rpd_pkg::MAG_W;
    localparam int TW  = ecg_rpd_pkg::TIME_W;
    localparam int THW = ecg_rpd_pkg::THR_W;
    localparam int SW  = ecg_rpd_pkg::SUM_W;
    localparam int CNW = ecg_rpd_pkg::CNT_W;
    localparam int RW  = ecg_rpd_pkg::RATE_W;
    localparam int DW  = ecg_rpd_pkg::DIV_W;

    // detector state
    logic [LW-1:0]  r_sig;
    logic [LW-1:0]  r_noise;
    logic [TW-1:0]  r_last;
    logic [MW-1:0]  r_prev;
    logic [MW-1:0]  r_cand;
    logic [TW-1:0]  r_cand_time;
    logic [TW-1:0]  r_ws;
    logic [SW-1:0]  r_sum;
    logic [CNW-1:0] r_cnt;
    logic [RW-1:0]  r_held;

    // captured sample and per-item results
    logic [MW-1:0]  r_mag;
    logic [TW-1:0]  r_time;
    logic           r_need_inst;
    logic           r_need_avg;
    logic           r_found;
    logic [TW-1:0]  r_pk_time;
    logic [RW-1:0]  r_rr;
    logic [RW-1:0]  r_inst;
    logic [SW-1:0]  r_win_sum;
    logic [CNW-1:0] r_win_cnt;

    // result register
    logic           r_o_found;
    logic [TW-1:0]  r_o_time;
    logic [RW-1:0]  r_o_rr;
    logic [RW-1:0]  r_o_inst;
    logic [RW-1:0]  r_o_avg;

    logic [MW-1:0]  w_neg;
    logic [MW-1:0]  w_mag_in;
    logic           w_only_min;
    logic [LW-1:0]  w_sig_base;
    logic           w_local_max;
    logic           w_above_min;
    logic           w_above_adapt;
    logic [THW-1:0] w_cand_sc;
    logic [THW-1:0] w_lhs;
    logic [THW-1:0] w_rhs;
    logic [TW-1:0]  w_rr;
    logic           w_rested;
    logic           w_accept;
    logic           w_rr_ok;
    logic [SW:0]    w_sum_ext;
    logic [SW-1:0]  w_sum1;
    logic [CNW-1:0] w_cnt1;
    logic [TW-1:0]  w_elapsed;
    logic           w_win_end;
    logic           w_div_done;
    logic [DW-1:0]  w_quo;
    logic [DW-1:0]  w_dividend;
    logic [DW-1:0]  w_divisor;

    // sample magnitude, -32768 gives 32768
    assign w_neg    = MW'(0) - {i_sample_value[ecg_rpd_pkg::SMP_W-1], i_sample_value};
    assign w_mag_in = i_sample_value[ecg_rpd_pkg::SMP_W-1] ? w_neg : {1'b0, i_sample_value};

    // empty signal level is seeded with the current magnitude
    assign w_only_min = (r_sig == '0);
    assign w_sig_base = w_only_min ? (LW'(r_mag) << F) : r_sig;

    // candidate tests
    assign w_local_max   = (r_cand >= r_prev) && (r_cand > r_mag);
    assign w_above_min   = r_cand >= MW'(i_cfg.min_thr);
    assign w_cand_sc     = THW'(r_cand) << F;
    assign w_lhs         = (w_cand_sc << 2) + w_cand_sc;
    assign w_rhs         = (THW'(r_noise) << 1) + (THW'(w_sig_base) << 1) + THW'(w_sig_base);
    assign w_above_adapt = w_only_min || (w_lhs >= w_rhs);
    assign w_rr          = r_cand_time - r_last;
    assign w_rested      = (r_last == '0) || (w_rr >= TW'(i_cfg.refr));
    assign w_accept      = w_local_max && w_above_min && w_above_adapt && w_rested;
    assign w_rr_ok       = w_accept && (r_last != '0) && (w_rr != '0)
                         && (w_rr >= TW'(i_cfg.rr_low)) && (w_rr <= TW'(i_cfg.rr_high));

    // saturating interval sum and count
    assign w_sum_ext = {1'b0, r_sum} + (SW + 1)'(w_rr);
    assign w_sum1    = !w_rr_ok ? r_sum : (w_sum_ext[SW] ? '1 : w_sum_ext[SW-1:0]);
    assign w_cnt1    = (w_rr_ok && (r_cnt != '1)) ? r_cnt + CNW'(1) : r_cnt;

    // rate window
    assign w_elapsed = r_time - r_ws;
    assign w_win_end = w_elapsed >= TW'(i_cfg.win_ms);

    // capture the accepted sample
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mag  <= w_mag_in;
            r_time <= i_sample_time;
        end
    end

    // state update for one item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig       <= '0;
            r_noise     <= '0;
            r_last      <= '0;
            r_prev      <= '0;
            r_cand      <= '0;
            r_cand_time <= '0;
            r_ws        <= ecg_rpd_pkg::RST_INIT_WS;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_held      <= '0;
            r_need_inst <= 1'b0;
            r_need_avg  <= 1'b0;
        end else if (i_cmd.calc) begin
            r_sig       <= w_accept ? ecg_rpd_pkg::track_level(w_sig_base, r_cand)
                                    : w_sig_base;
            if (w_local_max && !w_accept) begin
                r_noise <= ecg_rpd_pkg::track_level(r_noise, r_cand);
            end
            if (w_accept) begin
                r_last <= r_cand_time;
            end
            r_prev      <= r_cand;
            r_cand      <= r_mag;
            r_cand_time <= r_time;
            r_need_inst <= w_rr_ok;
            r_need_avg  <= w_win_end && (w_cnt1 != '0) && (w_sum1 != '0);
            if (w_win_end) begin
                r_sum <= '0;
                r_cnt <= '0;
                r_ws  <= r_time;
            end else begin
                r_sum <= w_sum1;
                r_cnt <= w_cnt1;
            end
        end else begin
            if (i_ws_load) begin
                r_ws <= i_ws_value;
            end
            if (i_cmd.cap_avg) begin
                r_held <= (|w_quo[DW-1:RW]) ? '1 : w_quo[RW-1:0];
            end
        end
    end

    // per-item values for the divider and the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_found   <= w_accept;
            r_pk_time <= w_accept ? r_cand_time : '0;
            r_rr      <= w_rr[RW-1:0];
            r_win_sum <= w_sum1;
            r_win_cnt <= w_cnt1;
        end
        if (i_cmd.cap_inst) begin
            r_inst <= w_quo[RW-1:0];
        end
    end

    // divider operands
    assign w_dividend = i_cmd.div_avg ? DW'(ecg_rpd_pkg::RATE_NUM) * DW'(r_win_cnt)
                                      : DW'(ecg_rpd_pkg::RATE_NUM);
    assign w_divisor  = i_cmd.div_avg ? DW'(r_win_sum) : DW'(r_rr);

    ecg_rpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_short    (!i_cmd.div_avg),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_found <= r_found;
            r_o_time  <= r_pk_time;
            r_o_rr    <= r_need_inst ? r_rr : '0;
            r_o_inst  <= r_need_inst ? r_inst : '0;
            r_o_avg   <= r_held;
        end
    end

    assign o_sts.need_inst = r_need_inst;
    assign o_sts.need_avg  = r_need_avg;
    assign o_sts.div_done  = w_div_done;

    assign o_peak_found   = r_o_found;
    assign o_peak_time    = r_o_time;
    assign o_rr_interval  = r_o_rr;
    assign o_instant_rate = r_o_inst;
    assign o_average_rate = r_o_avg;

endmodule

// ===== src/ecg_rpd_ctrl.sv =====
// ============================================================================
// ecg_rpd_ctrl - detector sequencer
// steps one sample through evaluation, the divisions it needs and the
// hand-off to the result register
// ============================================================================
module ecg_rpd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  ecg_rpd_pkg::t_sts i_sts,
    output ecg_rpd_pkg::t_cmd o_cmd
);

    ecg_rpd_pkg::t_state r_state;
    ecg_rpd_pkg::t_state n_state;
    logic                r_out_valid;
    logic                n_out_valid;

    // state and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ecg_rpd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ecg_rpd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ecg_rpd_pkg::S_CALC;
                end
            end
            ecg_rpd_pkg::S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = ecg_rpd_pkg::S_CHK;
            end
            ecg_rpd_pkg::S_CHK: begin
                if (i_sts.need_inst) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ecg_rpd_pkg::S_INST;
                end else if (i_sts.need_avg) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_avg   = 1'b1;
                    n_state         = ecg_rpd_pkg::S_AVG;
                end else begin
                    n_state = ecg_rpd_pkg::S_OUT;
                end
            end
            ecg_rpd_pkg::S_INST: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_inst = 1'b1;
                    if (i_sts.need_avg) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_avg   = 1'b1;
                        n_state         = ecg_rpd_pkg::S_AVG;
                    end else begin
                        n_state = ecg_rpd_pkg::S_OUT;
                    end
                end
            end
            ecg_rpd_pkg::S_AVG: begin
                o_cmd.div_avg = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.cap_avg = 1'b1;
                    n_state       = ecg_rpd_pkg::S_OUT;
                end
            end
            ecg_rpd_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ecg_rpd_pkg::S_IDLE;
                end
            end
            default: n_state = ecg_rpd_pkg::S_IDLE;
        endcase
    end

    // result valid: set on load, cleared when the beat is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_in_ready  = (r_state == ecg_rpd_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while waiting");

    // an accepted sample is evaluated in the next cycle
    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ecg_rpd_pkg::S_CALC))
        else $error("accepted sample not evaluated");

    // a new result only appears from the hand-off state
    a_out_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ecg_rpd_pkg::S_OUT))
        else $error("result valid rose outside hand-off");

    // divider completion only seen while waiting on it
    a_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == ecg_rpd_pkg::S_INST || r_state == ecg_rpd_pkg::S_AVG))
        else $error("divider done outside a division state");
`endif

endmodule

// ===== src/ecg_r_peak_detector_top.sv =====
// ============================================================================
// ecg_r_peak_detector_top - adaptive threshold r-peak detector
// takes filtered samples with timestamps, reports peaks, rr intervals,
// instant rate and a windowed average rate, one result beat per sample
// ============================================================================
//  channel   dir   handshake          payload
//  i_smp     in    valid / ready      sample_value, sample_time
//  o_res     out   valid / ready      peak_found, peak_time, rr_interval,
//                                     instant_rate, average_rate
//  apb       in    psel/penable       paddr, pwdata -> prdata, pready high
//
//  a sample with no division goes from acceptance through evaluation and the check
//  to the hand-off; a peak with a valid rr adds a division for the instant rate on
//  the shared radix-2 divider, and a closing rate window adds one for the average
//  ready is high only while the sequencer is idle, which it enters in the cycle
//  after each result loads; a stalled result at o_res holds the next sample in its
//  hand-off state; synchronous active-low reset
// ============================================================================
module ecg_r_peak_detector_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ecg_rpd_smp_if.sink                      i_smp,
    ecg_rpd_res_if.source                    o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ecg_rpd_pkg::PADDR_W-1:0]  paddr,
    input  logic [ecg_rpd_pkg::PDATA_W-1:0]  pwdata,
    output logic [ecg_rpd_pkg::PDATA_W-1:0]  prdata,
    output logic                             pready
);

    ecg_rpd_pkg::t_cfg                  w_cfg;
    ecg_rpd_pkg::t_cmd                  w_cmd;
    ecg_rpd_pkg::t_sts                  w_sts;
    logic                               w_ws_load;
    logic [ecg_rpd_pkg::TIME_W-1:0]     w_ws_value;
    logic                               w_in_ready;
    logic                               w_out_valid;

    // configuration registers
    ecg_rpd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_cfg      (w_cfg),
        .o_ws_load  (w_ws_load),
        .o_ws_value (w_ws_value)
    );

    // sequencer
    ecg_rpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_smp.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath
    ecg_rpd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_ws_load      (w_ws_load),
        .i_ws_value     (w_ws_value),
        .i_sample_value (i_smp.sample_value),
        .i_sample_time  (i_smp.sample_time),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_peak_found   (o_res.peak_found),
        .o_peak_time    (o_res.peak_time),
        .o_rr_interval  (o_res.rr_interval),
        .o_instant_rate (o_res.instant_rate),
        .o_average_rate (o_res.average_rate)
    );

    assign i_smp.ready = w_in_ready;
    assign o_res.valid = w_out_valid;

endmodule

// ===== test/tb_ecg_r_peak_detector_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_ecg_r_peak_detector_top - r-peak detector testbench
// opens with a short table of samples around reset, extremes, refractory
// rejects, a peak at timestamp zero and timestamp wrap; then six register
// settings with synthetic heartbeat trains and stray samples; every result
// beat is checked field by field against a typed row or a cycle-free predictor
// ============================================================================
module tb_ecg_r_peak_detector_top;

    localparam int SMP_W   = ecg_rpd_pkg::SMP_W;
    localparam int TIME_W  = ecg_rpd_pkg::TIME_W;
    localparam int RATE_W  = ecg_rpd_pkg::RATE_W;
    localparam int CFG_W   = ecg_rpd_pkg::CFG_W;
    localparam int LVL_W   = ecg_rpd_pkg::LVL_W;
    localparam int MAG_W   = ecg_rpd_pkg::MAG_W;
    localparam int SUM_W   = ecg_rpd_pkg::SUM_W;
    localparam int CNT_W   = ecg_rpd_pkg::CNT_W;
    localparam int PADDR_W = ecg_rpd_pkg::PADDR_W;
    localparam int PDATA_W = ecg_rpd_pkg::PDATA_W;
    localparam int FRAC_B  = ecg_rpd_pkg::LEVEL_FRACTION_BITS;

    // one result beat as seen on o_res
    typedef struct packed {
        logic              found;
        logic [TIME_W-1:0] ptime;
        logic [RATE_W-1:0] rr_ms;
        logic [RATE_W-1:0] bpm_now;
        logic [RATE_W-1:0] bpm_avg;
    } t_peak_report;

    // one row of the opening table
    typedef struct packed {
        logic signed [SMP_W-1:0] v;
        logic [TIME_W-1:0]       stamp;
        logic                    typed;
        t_peak_report            want;
    } t_opening_row;

    localparam logic [2:0]   REG_UNMAPPED = 3'd6;
    localparam t_peak_report QUIET_REPORT = '0;
    localparam t_peak_report FIRST_PEAK   = '{1'b1, 32'd4, 16'd0, 16'd0, 16'd0};

    // reset, extremes, refractory reject, min threshold reject, wrap,
    // peak at time zero and the first-peak rule after it
    localparam t_opening_row OPENING [22] = '{
        '{16'sd0,       32'd0,          1'b1, QUIET_REPORT},
        '{16'sd32767,   32'd4,          1'b1, QUIET_REPORT},
        '{16'sd0,       32'd8,          1'b1, FIRST_PEAK},
        '{-16'sd32768,  32'd12,         1'b1, QUIET_REPORT},
        '{16'sd0,       32'd500,        1'b0, QUIET_REPORT},
        '{16'sd30000,   32'd1000,       1'b0, QUIET_REPORT},
        '{-16'sd100,    32'd1004,       1'b0, QUIET_REPORT},
        '{16'sd899,     32'd1500,       1'b0, QUIET_REPORT},
        '{16'sd0,       32'd1504,       1'b0, QUIET_REPORT},
        '{16'sd32000,   32'd2000,       1'b0, QUIET_REPORT},
        '{-16'sd1,      32'd2004,       1'b0, QUIET_REPORT},
        '{16'sd5,       32'd2008,       1'b0, QUIET_REPORT},
        '{16'sd0,       32'hFFFF_FFFF,  1'b0, QUIET_REPORT},
        '{16'sd32767,   32'd0,          1'b0, QUIET_REPORT},
        '{16'sd0,       32'd4,          1'b0, QUIET_REPORT},
        '{16'sd32767,   32'd800,        1'b0, QUIET_REPORT},
        '{16'sd0,       32'd804,        1'b0, QUIET_REPORT},
        '{-16'sd32768,  32'd1600,       1'b0, QUIET_REPORT},
        '{-16'sd5,      32'd1604,       1'b0, QUIET_REPORT},
        '{16'sd12,      32'd1608,       1'b0, QUIET_REPORT},
        '{16'sh5555,    32'hAAAA_AAAA,  1'b0, QUIET_REPORT},
        '{16'shAAAA,    32'h5555_5555,  1'b0, QUIET_REPORT}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ecg_rpd_smp_if smp_bus ();
    ecg_rpd_res_if res_bus ();

    ecg_r_peak_detector_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // predictor registers
    logic [CFG_W-1:0]  min_thr_q, refr_q, win_q, rr_low_q, rr_high_q;
    // predictor detection state
    logic [LVL_W-1:0]  sig_lvl, noise_lvl;
    logic [TIME_W-1:0] last_peak, cand_time, win_start;
    logic [MAG_W-1:0]  prev_mag, cand_mag;
    logic [SUM_W-1:0]  rr_sum;
    logic [CNT_W-1:0]  rr_cnt;
    logic [RATE_W-1:0] held_bpm;

    t_peak_report      pending_reports [$];
    int                mismatches   = 0;
    int                src_idle_pct = 0;
    int                snk_idle_pct = 0;
    int                hold_pct     = 0;
    logic [TIME_W-1:0] now_ms;

    // level moves an eighth of the way toward the magnitude
    function automatic logic [LVL_W-1:0] follow_level(input logic [LVL_W-1:0] lvl,
                                                      input logic [MAG_W-1:0] mag);
        logic [31:0] acc;
        acc = (32'(mag) << FRAC_B) + 32'(lvl) * 7;
        return LVL_W'(acc >> 3);
    endfunction

    function automatic void restore_predictor();
        min_thr_q = ecg_rpd_pkg::RST_MIN_THR;
        refr_q    = ecg_rpd_pkg::RST_REFR;
        win_q     = ecg_rpd_pkg::RST_WIN_MS;
        rr_low_q  = ecg_rpd_pkg::RST_RR_LOW;
        rr_high_q = ecg_rpd_pkg::RST_RR_HIGH;
        sig_lvl   = '0;
        noise_lvl = '0;
        last_peak = '0;
        prev_mag  = '0;
        cand_mag  = '0;
        cand_time = '0;
        win_start = ecg_rpd_pkg::RST_INIT_WS;
        rr_sum    = '0;
        rr_cnt    = '0;
        held_bpm  = '0;
    endfunction

    function automatic void apply_setting(input logic [2:0] idx, input logic [PDATA_W-1:0] data);
        case (idx)
            ecg_rpd_pkg::REG_MIN_THR: min_thr_q = data[CFG_W-1:0];
            ecg_rpd_pkg::REG_REFR:    refr_q    = data[CFG_W-1:0];
            ecg_rpd_pkg::REG_WIN_MS:  win_q     = data[CFG_W-1:0];
            ecg_rpd_pkg::REG_RR_LOW:  rr_low_q  = data[CFG_W-1:0];
            ecg_rpd_pkg::REG_RR_HIGH: rr_high_q = data[CFG_W-1:0];
            ecg_rpd_pkg::REG_INIT_WS: win_start = data;
            default: ;
        endcase
    endfunction

    // judge the delayed candidate against the new sample, then roll the window
    function automatic t_peak_report detect_step(input logic signed [SMP_W-1:0] v,
                                                 input logic [TIME_W-1:0] stamp);
        logic [MAG_W-1:0]  mag;
        logic              only_min;
        logic              rested;
        logic [TIME_W-1:0] gap;
        logic [63:0]       lhs, rhs, avg;
        t_peak_report      r;
        r        = '0;
        mag      = v[SMP_W-1] ? MAG_W'(17'h10000 - {1'b0, v}) : {1'b0, v};
        only_min = 1'b0;
        // empty signal level takes the current magnitude, min threshold only
        if (sig_lvl == '0) begin
            sig_lvl  = LVL_W'(32'(mag) << FRAC_B);
            only_min = 1'b1;
        end
        if (cand_mag >= prev_mag && cand_mag > mag) begin
            lhs    = (64'(cand_mag) << FRAC_B) * 5;
            rhs    = 64'(noise_lvl) * 2 + 64'(sig_lvl) * 3;
            gap    = cand_time - last_peak;
            rested = (last_peak == '0) || (gap >= 32'(refr_q));
            if (cand_mag >= MAG_W'(min_thr_q) && (only_min || lhs >= rhs) && rested) begin
                r.found = 1'b1;
                r.ptime = cand_time;
                sig_lvl = follow_level(sig_lvl, cand_mag);
                // zero or out-of-range intervals do not count
                if (last_peak != '0 && gap != '0 && gap >= 32'(rr_low_q)
                        && gap <= 32'(rr_high_q)) begin
                    rr_sum = (rr_sum > 32'hFFFF_FFFF - gap) ? 32'hFFFF_FFFF : rr_sum + gap;
                    if (rr_cnt != 16'hFFFF) rr_cnt = rr_cnt + 1'b1;
                    r.rr_ms   = gap[RATE_W-1:0];
                    r.bpm_now = RATE_W'(32'(ecg_rpd_pkg::RATE_NUM) / gap);
                end
                last_peak = cand_time;
            end else begin
                noise_lvl = follow_level(noise_lvl, cand_mag);
            end
        end
        prev_mag  = cand_mag;
        cand_mag  = mag;
        cand_time = stamp;
        // window close: average the counted intervals, then restart
        if (TIME_W'(stamp - win_start) >= 32'(win_q)) begin
            if (rr_cnt != '0 && rr_sum != '0) begin
                avg      = (64'(ecg_rpd_pkg::RATE_NUM) * 64'(rr_cnt)) / 64'(rr_sum);
                held_bpm = (avg > 64'hFFFF) ? 16'hFFFF : avg[RATE_W-1:0];
            end
            rr_sum    = '0;
            rr_cnt    = '0;
            win_start = stamp;
        end
        r.bpm_avg = held_bpm;
        return r;
    endfunction

    // sample beat, predicted on acceptance
    task automatic send_sample(input logic signed [SMP_W-1:0] v, input logic [TIME_W-1:0] stamp,
                               input logic typed, input t_peak_report typed_report);
        t_peak_report predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            smp_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_bus.valid        <= 1'b1;
        smp_bus.sample_value <= v;
        smp_bus.sample_time  <= stamp;
        @(posedge i_clk);
        while (!smp_bus.ready) @(posedge i_clk);
        predicted = detect_step(v, stamp);
        pending_reports.push_back(typed ? typed_report : predicted);
    endtask

    // stop sending and let every pending result come back
    task automatic drain_reports();
        smp_bus.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // apb write: setup cycle, access cycle; psel stays up between writes
    task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        apply_setting(idx, data);
    endtask

    task automatic program_detector(input logic [31:0] min_thr, input logic [31:0] refr,
                                    input logic [31:0] win, input logic [31:0] low,
                                    input logic [31:0] high, input logic [31:0] ws);
        write_reg(ecg_rpd_pkg::REG_MIN_THR, min_thr);
        write_reg(ecg_rpd_pkg::REG_REFR, refr);
        write_reg(ecg_rpd_pkg::REG_WIN_MS, win);
        write_reg(ecg_rpd_pkg::REG_RR_LOW, low);
        write_reg(ecg_rpd_pkg::REG_RR_HIGH, high);
        write_reg(ecg_rpd_pkg::REG_INIT_WS, ws);
        write_reg(REG_UNMAPPED, $urandom);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] next_gap();
        if ($urandom_range(99) < hold_pct) return '0;
        if ($urandom_range(99) < 4) return TIME_W'($urandom_range(5000, 200));
        return TIME_W'($urandom_range(60, 8));
    endfunction

    task automatic send_paced(input int v);
        now_ms += next_gap();
        send_sample(SMP_W'(v), now_ms, 1'b0, QUIET_REPORT);
    endtask

    // heartbeat train: rise, peak, fall, quiet baseline; some stray samples
    task automatic play_rhythm(input int count);
        int left, amp, pk, v, q, n;
        left = count;
        amp  = $urandom_range(32767, 1000);
        while (left > 0) begin
            if ($urandom_range(99) < 15) begin
                // stray sample, sometimes at an arbitrary timestamp
                if ($urandom_range(3) == 0) now_ms = $urandom;
                else now_ms += next_gap();
                send_sample(SMP_W'($urandom), now_ms, 1'b0, QUIET_REPORT);
                left--;
            end else begin
                if ($urandom_range(7) == 0) begin
                    v = $urandom_range(1) ? -32768 : 32767;
                end else begin
                    pk = amp + int'($urandom_range(amp / 4)) - amp / 8;
                    pk = (pk > 32767) ? 32767 : (pk < 1) ? 1 : pk;
                    v  = $urandom_range(1) ? -pk : pk;
                end
                if ($urandom_range(99) < hold_pct) begin
                    // twin peaks on one timestamp
                    send_sample(SMP_W'(v), now_ms, 1'b0, QUIET_REPORT);
                    send_sample(SMP_W'(v / 3), now_ms, 1'b0, QUIET_REPORT);
                    send_sample(SMP_W'(v), now_ms, 1'b0, QUIET_REPORT);
                    send_sample(SMP_W'(v / 3), now_ms, 1'b0, QUIET_REPORT);
                    left -= 4;
                end else begin
                    send_paced(v / 2);
                    send_paced(v);
                    send_paced(v / 3);
                    left -= 3;
                end
                q = amp / 10 + 1;
                n = $urandom_range(25, 4);
                for (int j = 0; j < n; j++) send_paced(int'($urandom_range(2 * q)) - q);
                left -= n;
            end
        end
    endtask

    task automatic flag_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, label, want, got);
            mismatches++;
        end
    endtask

    // result side: random stalls, in-order compare
    always @(posedge i_clk) begin : sink_side
        t_peak_report want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: result beat with no sample pending", $time);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                flag_field("peak_found", 32'(want.found), 32'(res_bus.peak_found));
                flag_field("peak_time", want.ptime, res_bus.peak_time);
                flag_field("rr_interval", 32'(want.rr_ms), 32'(res_bus.rr_interval));
                flag_field("instant_rate", 32'(want.bpm_now), 32'(res_bus.instant_rate));
                flag_field("average_rate", 32'(want.bpm_avg), 32'(res_bus.average_rate));
            end
        end
        res_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // run limit
    initial begin
        #(10_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        smp_bus.valid        = 1'b0;
        smp_bus.sample_value = '0;
        smp_bus.sample_time  = '0;
        res_bus.ready        = 1'b0;
        now_ms               = '0;
        restore_predictor();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // opening table under reset settings
        src_idle_pct = 27;
        snk_idle_pct = 74;
        for (int i = 0; i < $size(OPENING); i++)
            send_sample(OPENING[i].v, OPENING[i].stamp, OPENING[i].typed, OPENING[i].want);
        drain_reports();

        for (int p = 0; p < 6; p++) begin
            src_idle_pct = (p < 2) ? 27 : (p < 4) ? 74 : 0;
            snk_idle_pct = (p < 2) ? 74 : (p < 4) ? 27 : 0;
            case (p)
                0: begin
                    // low extremes, zero refractory, repeated timestamps
                    program_detector(0, 0, 1, 1, 65535, 0);
                    hold_pct = 20;
                end
                1: begin
                    // high extremes, inverted rr range
                    program_detector(32768, 65535, 65535, 65535, 1, 32'hFFFF_FFFF);
                    hold_pct = 0;
                end
                2: begin
                    program_detector($urandom_range(1500, 200), $urandom_range(400, 200),
                                     $urandom_range(6000, 1000), $urandom_range(300, 150),
                                     $urandom_range(2500, 1500), $urandom);
                    hold_pct = 0;
                end
                3: begin
                    program_detector($urandom_range(1500, 200), $urandom_range(400, 150),
                                     $urandom_range(3000, 500), 1200, 300, $urandom);
                    hold_pct = 5;
                end
                4: begin
                    program_detector($urandom_range(32768, 0), $urandom_range(65535, 0),
                                     $urandom_range(65535, 1), $urandom_range(65535, 1),
                                     $urandom_range(65535, 1), $urandom);
                    hold_pct = 5;
                end
                default: begin
                    program_detector($urandom_range(900, 0), 0, $urandom_range(2000, 1),
                                     $urandom_range(250, 1), $urandom_range(2000, 800),
                                     $urandom);
                    hold_pct = 10;
                end
            endcase
            now_ms = $urandom;
            play_rhythm(105);
            drain_reports();
            play_rhythm(105);
            drain_reports();
        end

        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
